// File: hdl/swaabb_pkg.sv
package swaabb_pkg;

	typedef enum logic [1:0] {
		CLS_OVERLAP,
		CLS_CROSS,
		CLS_MISS
	} axis_cls_t;

	typedef enum logic [2:0] {
		SEL_PASS,
		SEL_X,
		SEL_Y,
		SEL_Z,
		SEL_NEG
	} clip_sel_t;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;
	localparam int TolW = 16;

	localparam logic [CfgIdxW-1:0] REG_MOVER_MIN_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MOVER_MIN_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MOVER_MIN_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MOVER_MAX_X = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MOVER_MAX_Y = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_MOVER_MAX_Z = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SKIN_TOL = 3'd6;

	localparam logic [TolW-1:0] TOL_RESET = 16'd66;

endpackage

// File: hdl/swaabb_if.sv
interface swaabb_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] move_x;
	logic signed [31:0] move_y;
	logic signed [31:0] move_z;
	logic signed [31:0] obstacle_min_x;
	logic signed [31:0] obstacle_min_y;
	logic signed [31:0] obstacle_min_z;
	logic signed [31:0] obstacle_max_x;
	logic signed [31:0] obstacle_max_y;
	logic signed [31:0] obstacle_max_z;

	modport source (output valid, move_x, move_y, move_z, obstacle_min_x, obstacle_min_y,
		obstacle_min_z, obstacle_max_x, obstacle_max_y, obstacle_max_z, input ready);
	modport sink (input valid, move_x, move_y, move_z, obstacle_min_x, obstacle_min_y,
		obstacle_min_z, obstacle_max_x, obstacle_max_y, obstacle_max_z, output ready);
endinterface

interface swaabb_out_if;
	logic valid;
	logic ready;
	logic collided;
	logic signed [31:0] safe_move_x;
	logic signed [31:0] safe_move_y;
	logic signed [31:0] safe_move_z;

	modport source (output valid, collided, safe_move_x, safe_move_y, safe_move_z,
		input ready);
	modport sink (input valid, collided, safe_move_x, safe_move_y, safe_move_z,
		output ready);
endinterface

// File: hdl/swaabb_lane.sv
module swaabb_lane
	import swaabb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic [FRAC_BITS:0]    en,
	input  logic signed [31:0]    pmin,
	input  logic signed [31:0]    pmax,
	input  logic [TolW-1:0]       tol,
	input  logic signed [31:0]    m,
	input  logic signed [31:0]    omin,
	input  logic signed [31:0]    omax,
	output axis_cls_t             cls,
	output logic [FRAC_BITS-1:0]  t,
	output logic signed [31:0]    m_o
);

	axis_cls_t cls_s [FRAC_BITS+1];
	logic [31:0] rem_s [FRAC_BITS+1];
	logic [31:0] d_s [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] q_s [FRAC_BITS+1];
	logic signed [31:0] m_s [FRAC_BITS+1];

	logic signed [33:0] tol_w, omin_w, omax_w, pmin_w, pmax_w, m_w;
	logic signed [33:0] diff_lo, diff_hi;
	axis_cls_t cls_c;
	logic [31:0] num_c, d_c;

	always_comb begin
		tol_w = $signed({18'd0, tol});
		pmin_w = {{2{pmin[31]}}, pmin};
		pmax_w = {{2{pmax[31]}}, pmax};
		m_w = {{2{m[31]}}, m};
		omin_w = {{2{omin[31]}}, omin} + tol_w;
		omax_w = {{2{omax[31]}}, omax} - tol_w;
		diff_lo = omin_w - pmax_w;
		diff_hi = pmin_w - omax_w;
		cls_c = CLS_MISS;
		num_c = '0;
		d_c = 32'd1;
		if (pmax_w > omin_w && pmin_w < omax_w) begin
			cls_c = CLS_OVERLAP;
		end else if (pmax_w <= omin_w && pmax_w + m_w > omin_w) begin
			cls_c = CLS_CROSS;
			num_c = diff_lo[31:0];
			d_c = m_w[31:0];
		end else if (pmin_w >= omax_w && pmin_w + m_w < omax_w) begin
			cls_c = CLS_CROSS;
			num_c = diff_hi[31:0];
			d_c = 32'(-m_w);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cls_s[0] <= cls_c;
			rem_s[0] <= num_c;
			d_s[0] <= d_c;
			q_s[0] <= '0;
			m_s[0] <= m;
		end
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
		logic [32:0] rem2;
		logic [32:0] diff;
		logic ge;

		always_comb begin
			rem2 = {rem_s[k-1], 1'b0};
			diff = rem2 - {1'b0, d_s[k-1]};
			ge = rem2 >= {1'b0, d_s[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				cls_s[k] <= cls_s[k-1];
				rem_s[k] <= ge ? diff[31:0] : rem2[31:0];
				d_s[k] <= d_s[k-1];
				q_s[k] <= {q_s[k-1][FRAC_BITS-2:0], ge};
				m_s[k] <= m_s[k-1];
			end
		end
	end

	assign cls = cls_s[FRAC_BITS];
	assign t = q_s[FRAC_BITS];
	assign m_o = m_s[FRAC_BITS];

endmodule

// File: hdl/swaabb_merge.sv
module swaabb_merge
	import swaabb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic [1:0]            en,
	input  logic [TolW-1:0]       tol,
	input  axis_cls_t             cls [3],
	input  logic [FRAC_BITS-1:0]  t [3],
	input  logic signed [31:0]    m [3],
	output logic                  collided,
	output logic signed [31:0]    safe_x,
	output logic signed [31:0]    safe_y,
	output logic signed [31:0]    safe_z
);

	clip_sel_t sel_c, sel_s1;
	logic [31:0] mag_c;
	logic [FRAC_BITS-1:0] t_c;
	logic [31+FRAC_BITS:0] prod_s1;
	logic signed [31:0] m_s1 [3];
	logic [2:0] cr;
	logic pick_x, pick_y, pick_z;

	logic [31:0] cut, cut_t;
	logic signed [31:0] clip_v, msel;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i] = cls[i] == CLS_CROSS;
		end
		pick_x = cr[0] && (!cr[1] || t[0] >= t[1]) && (!cr[2] || t[0] >= t[2]);
		pick_y = cr[1] && (!cr[0] || t[1] >= t[0]) && (!cr[2] || t[1] >= t[2]);
		pick_z = cr[2] && (!cr[0] || t[2] >= t[0]) && (!cr[1] || t[2] >= t[1]);
		if (cls[0] == CLS_MISS || cls[1] == CLS_MISS || cls[2] == CLS_MISS) begin
			sel_c = SEL_PASS;
		end else if (pick_x) begin
			sel_c = SEL_X;
		end else if (pick_y) begin
			sel_c = SEL_Y;
		end else if (pick_z) begin
			sel_c = SEL_Z;
		end else begin
			sel_c = SEL_NEG;
		end
		case (sel_c)
			SEL_Y: begin
				mag_c = m[1][31] ? 32'(-m[1]) : m[1];
				t_c = t[1];
			end
			SEL_Z: begin
				mag_c = m[2][31] ? 32'(-m[2]) : m[2];
				t_c = t[2];
			end
			default: begin
				mag_c = m[0][31] ? 32'(-m[0]) : m[0];
				t_c = t[0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sel_s1 <= sel_c;
			prod_s1 <= mag_c * t_c;
			for (int i = 0; i < 3; i++) begin
				m_s1[i] <= m[i];
			end
		end
	end

	always_comb begin
		case (sel_s1)
			SEL_Y: msel = m_s1[1];
			SEL_Z: msel = m_s1[2];
			default: msel = m_s1[0];
		endcase
		cut = prod_s1[31+FRAC_BITS:FRAC_BITS];
		cut_t = (cut > {16'd0, tol}) ? cut - {16'd0, tol} : '0;
		clip_v = msel[31] ? $signed(32'(-cut_t)) : $signed(cut_t);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			collided <= sel_s1 != SEL_PASS;
			safe_x <= m_s1[0];
			safe_y <= m_s1[1];
			safe_z <= m_s1[2];
			case (sel_s1)
				SEL_X: safe_x <= clip_v;
				SEL_Y: safe_y <= clip_v;
				SEL_Z: safe_z <= clip_v;
				SEL_NEG: begin
					safe_x <= 32'(-m_s1[0]);
					safe_y <= 32'(-m_s1[1]);
					safe_z <= 32'(-m_s1[2]);
				end
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/swept_aabb_collision_clip_unit.sv
// Channel   Role    Payload
// in_ch     sink    move_x/y/z, obstacle_min_x/y/z, obstacle_max_x/y/z
// out_ch    source  collided, safe_move_x/y/z
// cfg_*     write   cfg_we, cfg_idx, cfg_data
//
// One item is accepted every cycle while in_ch.ready is high; a full pipeline under an output stall holds it low.
// The per-axis divider resolves one quotient bit per stage.
// Every stage holds its own valid bit, so bubbles are squeezed out under an output stall.
// Reset clears the valid bits and loads the configuration reset values.
module swept_aabb_collision_clip_unit
	import swaabb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_idx,
	input  logic [CfgDataW-1:0]  cfg_data,
	swaabb_in_if.sink            in_ch,
	swaabb_out_if.source         out_ch
);

	localparam int NStg = FRAC_BITS + 3;

	logic signed [31:0] pmin_q [3];
	logic signed [31:0] pmax_q [3];
	logic [TolW-1:0] tol_q;

	logic [NStg-1:0] v_q;
	logic [NStg-1:0] en;

	logic signed [31:0] mv [3];
	logic signed [31:0] omin [3];
	logic signed [31:0] omax [3];
	axis_cls_t cls [3];
	logic [FRAC_BITS-1:0] t [3];
	logic signed [31:0] m_l [3];
	logic any_miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pmin_q[i] <= '0;
				pmax_q[i] <= '0;
			end
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MOVER_MIN_X: pmin_q[0] <= cfg_data;
				REG_MOVER_MIN_Y: pmin_q[1] <= cfg_data;
				REG_MOVER_MIN_Z: pmin_q[2] <= cfg_data;
				REG_MOVER_MAX_X: pmax_q[0] <= cfg_data;
				REG_MOVER_MAX_Y: pmax_q[1] <= cfg_data;
				REG_MOVER_MAX_Z: pmax_q[2] <= cfg_data;
				REG_SKIN_TOL: tol_q <= cfg_data[TolW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		en[NStg-1] = !v_q[NStg-1] || out_ch.ready;
		for (int i = NStg - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_ch.valid;
			end
			for (int i = 1; i < NStg; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign in_ch.ready = en[0];
	assign out_ch.valid = v_q[NStg-1];

	assign mv[0] = in_ch.move_x;
	assign mv[1] = in_ch.move_y;
	assign mv[2] = in_ch.move_z;
	assign omin[0] = in_ch.obstacle_min_x;
	assign omin[1] = in_ch.obstacle_min_y;
	assign omin[2] = in_ch.obstacle_min_z;
	assign omax[0] = in_ch.obstacle_max_x;
	assign omax[1] = in_ch.obstacle_max_y;
	assign omax[2] = in_ch.obstacle_max_z;

	for (genvar a = 0; a < 3; a++) begin : g_lane
		swaabb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk  (clk),
			.en   (en[FRAC_BITS:0]),
			.pmin (pmin_q[a]),
			.pmax (pmax_q[a]),
			.tol  (tol_q),
			.m    (mv[a]),
			.omin (omin[a]),
			.omax (omax[a]),
			.cls  (cls[a]),
			.t    (t[a]),
			.m_o  (m_l[a])
		);
	end

	swaabb_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk      (clk),
		.en       (en[NStg-1:NStg-2]),
		.tol      (tol_q),
		.cls      (cls),
		.t        (t),
		.m        (m_l),
		.collided (out_ch.collided),
		.safe_x   (out_ch.safe_move_x),
		.safe_y   (out_ch.safe_move_y),
		.safe_z   (out_ch.safe_move_z)
	);

	assign any_miss = cls[0] == CLS_MISS || cls[1] == CLS_MISS || cls[2] == CLS_MISS;

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> &v_q)
		else $error("Input stalled while the pipeline has a bubble.");

	a_miss_passes: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NStg-3] && en[NStg-2] && any_miss
		|=> en[NStg-1] [->1] ##1 !out_ch.collided)
		else $error("A missed axis produced a collision.");

	a_out_follows_merge: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NStg-2] && en[NStg-1] |=> out_ch.valid)
		else $error("A merged result was dropped.");

endmodule

// File: verif/swaabb_clip_checker.sv
module swaabb_clip_checker
	import swaabb_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	swaabb_in_if                in_ch,
	swaabb_out_if               out_ch,
	output int                  errors,
	output int                  pending,
	output int                  checked,
	output int                  hits
);

	typedef struct packed {
		logic               collided;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
	} clip_result_t;

	localparam longint TONE = longint'(1) << FRAC_BITS;

	longint box_min[3];
	longint box_max[3];
	longint skin;
	clip_result_t expected_moves[$];

	assign pending = expected_moves.size();

	function automatic longint entry_time(longint pmin, longint pmax, longint omin,
		longint omax, longint m);
		if (pmax > omin && pmin < omax)
			return -TONE;
		if (pmax <= omin && pmax + m > omin)
			return ((omin - pmax) << FRAC_BITS) / m;
		if (pmin >= omax && pmin + m < omax)
			return ((pmin - omax) << FRAC_BITS) / (-m);
		return 2 * TONE;
	endfunction

	function automatic logic signed [31:0] clip_axis(longint m, longint t);
		longint mag;
		longint cut;
		mag = (m < 0) ? -m : m;
		cut = (mag * t) >>> FRAC_BITS;
		cut = (cut > skin) ? cut - skin : 0;
		return (m < 0) ? 32'(-cut) : 32'(cut);
	endfunction

	function automatic clip_result_t predict_clip(longint mv[3], longint omn[3],
		longint omx[3]);
		clip_result_t r;
		longint t[3];
		clip_sel_t sel;
		for (int a = 0; a < 3; a++)
			t[a] = entry_time(box_min[a], box_max[a], omn[a] + skin, omx[a] - skin, mv[a]);
		if (t[0] > TONE || t[1] > TONE || t[2] > TONE)
			sel = SEL_PASS;
		else if (t[0] >= 0 && t[0] >= t[1] && t[0] >= t[2])
			sel = SEL_X;
		else if (t[1] >= 0 && t[1] >= t[0] && t[1] >= t[2])
			sel = SEL_Y;
		else if (t[2] >= 0 && t[2] >= t[0] && t[2] >= t[1])
			sel = SEL_Z;
		else
			sel = SEL_NEG;
		r.collided = (sel != SEL_PASS);
		r.sx = 32'(mv[0]);
		r.sy = 32'(mv[1]);
		r.sz = 32'(mv[2]);
		case (sel)
			SEL_X: r.sx = clip_axis(mv[0], t[0]);
			SEL_Y: r.sy = clip_axis(mv[1], t[1]);
			SEL_Z: r.sz = clip_axis(mv[2], t[2]);
			SEL_NEG: begin
				r.sx = 32'(-mv[0]);
				r.sy = 32'(-mv[1]);
				r.sz = 32'(-mv[2]);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", checked, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint mv[3];
		longint omn[3];
		longint omx[3];
		clip_result_t want;
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_min[a] = 0;
				box_max[a] = 0;
			end
			skin = longint'(TOL_RESET);
			errors = 0;
			checked = 0;
			hits = 0;
			expected_moves.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MOVER_MIN_X: box_min[0] = longint'($signed(cfg_data));
					REG_MOVER_MIN_Y: box_min[1] = longint'($signed(cfg_data));
					REG_MOVER_MIN_Z: box_min[2] = longint'($signed(cfg_data));
					REG_MOVER_MAX_X: box_max[0] = longint'($signed(cfg_data));
					REG_MOVER_MAX_Y: box_max[1] = longint'($signed(cfg_data));
					REG_MOVER_MAX_Z: box_max[2] = longint'($signed(cfg_data));
					REG_SKIN_TOL: skin = longint'(cfg_data[TolW-1:0]);
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				mv[0] = in_ch.move_x;
				mv[1] = in_ch.move_y;
				mv[2] = in_ch.move_z;
				omn[0] = in_ch.obstacle_min_x;
				omn[1] = in_ch.obstacle_min_y;
				omn[2] = in_ch.obstacle_min_z;
				omx[0] = in_ch.obstacle_max_x;
				omx[1] = in_ch.obstacle_max_y;
				omx[2] = in_ch.obstacle_max_z;
				expected_moves.push_back(predict_clip(mv, omn, omx));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_moves.size() == 0) begin
					report("unexpected transfer", 0, 0);
				end else begin
					want = expected_moves.pop_front();
					if (out_ch.collided !== want.collided)
						report("collided", out_ch.collided, want.collided);
					if (out_ch.safe_move_x !== want.sx)
						report("safe_move_x", out_ch.safe_move_x, want.sx);
					if (out_ch.safe_move_y !== want.sy)
						report("safe_move_y", out_ch.safe_move_y, want.sy);
					if (out_ch.safe_move_z !== want.sz)
						report("safe_move_z", out_ch.safe_move_z, want.sz);
					if (want.collided)
						hits++;
				end
				checked++;
			end
		end
	end

endmodule

// File: verif/tb_swept_aabb_collision_clip_unit.sv
module tb_swept_aabb_collision_clip_unit;
	import swaabb_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_data;
	int errors;
	int pending;
	int checked;
	int hits;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int sent;
	int settings;
	longint box_min[3];
	longint box_max[3];

	swaabb_in_if in_ch ();
	swaabb_out_if out_ch ();

	swept_aabb_collision_clip_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	swaabb_clip_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.hits(hits)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(negedge clk) begin
		if (hold_req) begin
			out_ch.ready = 1'b0;
			repeat (300) @(negedge clk);
			hold_req = 1'b0;
		end else begin
			out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, longint value);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = CfgDataW'(value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_mover(longint mn[3], longint mx[3], longint tol);
		write_reg(REG_MOVER_MIN_X, mn[0]);
		write_reg(REG_MOVER_MIN_Y, mn[1]);
		write_reg(REG_MOVER_MIN_Z, mn[2]);
		write_reg(REG_MOVER_MAX_X, mx[0]);
		write_reg(REG_MOVER_MAX_Y, mx[1]);
		write_reg(REG_MOVER_MAX_Z, mx[2]);
		write_reg(REG_SKIN_TOL, tol);
		box_min = mn;
		box_max = mx;
		settings++;
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic send_move(longint mv[3], longint omn[3], longint omx[3]);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.move_x = 32'(mv[0]);
		in_ch.move_y = 32'(mv[1]);
		in_ch.move_z = 32'(mv[2]);
		in_ch.obstacle_min_x = 32'(omn[0]);
		in_ch.obstacle_min_y = 32'(omn[1]);
		in_ch.obstacle_min_z = 32'(omn[2]);
		in_ch.obstacle_max_x = 32'(omx[0]);
		in_ch.obstacle_max_y = 32'(omx[1]);
		in_ch.obstacle_max_z = 32'(omx[2]);
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_random_move();
		longint mv[3];
		longint omn[3];
		longint omx[3];
		longint gap;
		longint span;
		int shape;
		shape = $urandom_range(9);
		for (int a = 0; a < 3; a++) begin
			gap = $urandom_range(0, 1 << 17);
			span = $urandom_range(0, 1 << 18);
			if (shape == 9) begin
				mv[a] = $signed($urandom());
				omn[a] = $signed($urandom());
				omx[a] = $signed($urandom());
			end else if (shape == 8) begin
				mv[a] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
				omn[a] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
				omx[a] = omn[a] + span;
			end else begin
				case ($urandom_range(2))
					0: begin
						omn[a] = box_min[a] - gap;
						omx[a] = box_max[a] + span;
						mv[a] = longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
					end
					1: begin
						omn[a] = box_max[a] + gap;
						omx[a] = omn[a] + span;
						mv[a] = $urandom_range(0, 3 * gap + 1000);
					end
					default: begin
						omx[a] = box_min[a] - gap;
						omn[a] = omx[a] - span;
						mv[a] = -longint'($urandom_range(0, 3 * gap + 1000));
					end
				endcase
			end
		end
		send_move(mv, omn, omx);
	endtask

	task automatic send_directed();
		longint lo[3] = '{-ONE, -ONE, -ONE};
		longint hi[3] = '{2 * ONE, 2 * ONE, 2 * ONE};
		longint zero3[3] = '{0, 0, 0};
		longint far_lo[3] = '{-2147483648, -2147483648, -2147483648};
		longint far_hi[3] = '{2147483647, 2147483647, 2147483647};
		send_move('{ONE, -ONE, 7}, lo, hi);
		send_move('{-2147483648, 2147483647, 0}, lo, hi);
		send_move('{2 * ONE, 5, -5}, '{2 * ONE, -ONE, -ONE}, '{3 * ONE, 2 * ONE, 2 * ONE});
		send_move('{-2 * ONE, 5, -5}, '{-3 * ONE, -ONE, -ONE}, '{-ONE, 2 * ONE, 2 * ONE});
		send_move('{ONE / 2, 0, 0}, '{2 * ONE, -ONE, -ONE}, '{3 * ONE, 2 * ONE, 2 * ONE});
		send_move('{2 * ONE, 2 * ONE, 0}, '{2 * ONE, 2 * ONE, -ONE},
			'{3 * ONE, 3 * ONE, 2 * ONE});
		send_move('{ONE, 4 * ONE, 0}, '{2 * ONE, 2 * ONE, -ONE}, '{3 * ONE, 3 * ONE, 2 * ONE});
		send_move('{0, 0, -4 * ONE}, '{-ONE, -ONE, -3 * ONE}, '{2 * ONE, 2 * ONE, -ONE});
		send_move('{ONE + 70, 0, 0}, '{ONE, -ONE, -ONE}, '{3 * ONE, 2 * ONE, 2 * ONE});
		send_move('{2147483647, 0, 0}, '{ONE, -ONE, -ONE}, '{3 * ONE, 2 * ONE, 2 * ONE});
		send_move('{-2147483648, 0, 0}, '{-3 * ONE, -ONE, -ONE}, '{-ONE, 2 * ONE, 2 * ONE});
		send_move(zero3, far_lo, far_hi);
		send_move(far_hi, far_lo, far_hi);
		send_move(far_lo, far_hi, far_lo);
		send_move(zero3, far_hi, far_lo);
		send_move('{5 * ONE, 5 * ONE, 5 * ONE}, '{2 * ONE, 2 * ONE, 2 * ONE},
			'{3 * ONE, 3 * ONE, 3 * ONE});
		send_move('{-ONE, ONE, ONE}, '{2 * ONE, 2 * ONE, 2 * ONE}, '{3 * ONE, 3 * ONE, 3 * ONE});
	endtask

	initial begin
		longint mn[3];
		longint mx[3];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent = 0;
		settings = 1;
		box_min = '{0, 0, 0};
		box_max = '{0, 0, 0};
		in_ch.valid = 1'b0;
		in_ch.move_x = '0;
		in_ch.move_y = '0;
		in_ch.move_z = '0;
		in_ch.obstacle_min_x = '0;
		in_ch.obstacle_min_y = '0;
		in_ch.obstacle_min_z = '0;
		in_ch.obstacle_max_x = '0;
		in_ch.obstacle_max_y = '0;
		in_ch.obstacle_max_z = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		repeat (60) send_random_move();
		drain();
		set_mover('{0, 0, 0}, '{ONE, ONE, ONE}, 66);
		send_directed();

		for (int cfg = 0; cfg < 6; cfg++) begin
			case (cfg)
				0: ;
				1: set_mover('{-2147483648, -2147483648, -2147483648},
					'{2147483647, 2147483647, 2147483647}, 65535);
				2: set_mover('{2147483647, 2147483647, 2147483647},
					'{-2147483648, -2147483648, -2147483648}, 0);
				3: begin
					for (int a = 0; a < 3; a++) begin
						mn[a] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
						mx[a] = mn[a] + $urandom_range(0, 2 * ONE);
					end
					set_mover(mn, mx, 0);
				end
				4: begin
					for (int a = 0; a < 3; a++) begin
						mx[a] = longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
						mn[a] = mx[a] + $urandom_range(0, ONE);
					end
					set_mover(mn, mx, $urandom_range(0, 65535));
				end
				default: begin
					for (int a = 0; a < 3; a++) begin
						mn[a] = $signed($urandom());
						mx[a] = $signed($urandom());
					end
					set_mover(mn, mx, $urandom_range(0, 65535));
				end
			endcase
			for (int ph = 0; ph < 4; ph++) begin
				send_idle_pct = (ph == 1 || ph == 3) ? 66 : 0;
				recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 8 : 0;
				if (ph == 3)
					send_idle_pct = 8;
				if (ph == 0 && cfg == 0)
					hold_req = 1'b1;
				repeat (75) send_random_move();
			end
			send_idle_pct = 0;
			recv_stall_pct = 0;
			drain();
		end

		$display("Sent %0d moves across %0d mover settings; %0d results checked, %0d collided.",
			sent, settings, checked, hits);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
